@@ rtl/core/a85_pkg.sv @@
// Shared types and constants for the ascii85 tuple encoder.
package a85_pkg;

	localparam int unsigned A85_WORD_W  = 32;
	localparam int unsigned A85_CHAR_W  = 7;
	localparam int unsigned A85_PROD_W  = 64;
	localparam int unsigned A85_SHIFT   = 38;
	localparam int unsigned A85_QUOT_W  = A85_PROD_W - A85_SHIFT;
	localparam int unsigned A85_QDEPTH  = 2;
	localparam int unsigned A85_QPTR_W  = 1;
	localparam int unsigned A85_QCNT_W  = 2;
	localparam int unsigned A85_DIGITS  = 5;
	localparam int unsigned A85_DCNT_W  = 3;

	localparam logic [A85_WORD_W-1:0] A85_RECIP     = 32'd3233857729;
	localparam logic [A85_CHAR_W-1:0] A85_BASE      = 7'd85;
	localparam logic [A85_CHAR_W-1:0] A85_OFFSET    = 7'd33;
	localparam logic [A85_CHAR_W-1:0] A85_ZERO_CHAR = 7'd122;

	typedef struct packed {
		logic [A85_WORD_W-1:0] value;
		logic                  zero;
	} a85_entry_t;

	typedef struct packed {
		logic       valid;
		a85_entry_t entry;
	} a85_head_t;

endpackage

@@ rtl/core/a85_front.sv @@
// Front end: accepts input beats, swaps bytes and flags all-zero words.
module a85_front (
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [a85_pkg::A85_WORD_W-1:0] word,
	input  logic                           full,
	output logic                           push,
	output a85_pkg::a85_entry_t            entry
);

	always_comb begin
		entry.value = {word[7:0], word[15:8], word[23:16], word[31:24]};
		entry.zero  = (word == '0);
		in_stall    = full;
		push        = in_valid && !full;
	end

endmodule

@@ rtl/core/a85_queue.sv @@
// Two-entry queue between the front end and the digit back end.
module a85_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  a85_pkg::a85_entry_t entry,
	output logic                full,
	input  logic                pop,
	output a85_pkg::a85_head_t  head
);

	a85_pkg::a85_entry_t                 mem_q [a85_pkg::A85_QDEPTH];
	logic [a85_pkg::A85_QPTR_W-1:0]      wr_ptr_q;
	logic [a85_pkg::A85_QPTR_W-1:0]      rd_ptr_q;
	logic [a85_pkg::A85_QCNT_W-1:0]      count_q;

	always_comb begin
		full       = (count_q == a85_pkg::A85_QCNT_W'(a85_pkg::A85_QDEPTH));
		head.valid = (count_q != '0);
		head.entry = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

endmodule

@@ rtl/core/a85_back.sv @@
// Back end: base-85 digit unit and output character serializer.
module a85_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  a85_pkg::a85_head_t             head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [a85_pkg::A85_CHAR_W-1:0] character,
	output logic                           last
);

	logic                                 busy_q;
	logic [1:0]                           cnt_q;
	logic [a85_pkg::A85_PROD_W-1:0]       prod_q;
	logic [a85_pkg::A85_WORD_W-1:0]       vprev_q;
	logic [a85_pkg::A85_CHAR_W-1:0]       lo_q [3];
	logic [a85_pkg::A85_CHAR_W-1:0]       ser_q [a85_pkg::A85_DIGITS];
	logic [a85_pkg::A85_DCNT_W-1:0]       rem_q;

	logic [a85_pkg::A85_QUOT_W-1:0]       quot;
	logic [a85_pkg::A85_CHAR_W-1:0]       quot7;
	logic [a85_pkg::A85_CHAR_W-1:0]       digit;
	logic                                 ser_free;
	logic                                 out_take;
	logic                                 start;
	logic                                 zstart;
	logic                                 step;
	logic                                 finish;

	always_comb begin
		quot     = prod_q[a85_pkg::A85_PROD_W-1:a85_pkg::A85_SHIFT];
		quot7    = quot[a85_pkg::A85_CHAR_W-1:0];
		digit    = vprev_q[a85_pkg::A85_CHAR_W-1:0]
			- a85_pkg::A85_CHAR_W'(quot7 * a85_pkg::A85_BASE);
		out_take = (rem_q != '0) && !out_stall;
		ser_free = (rem_q == '0) || (out_take && rem_q == a85_pkg::A85_DCNT_W'(1));
		start    = head.valid && !busy_q && !head.entry.zero;
		zstart   = head.valid && !busy_q && head.entry.zero && ser_free;
		step     = busy_q && (cnt_q != 2'd3);
		finish   = busy_q && (cnt_q == 2'd3) && ser_free;
		pop      = start || zstart;
	end

	always_comb begin
		out_valid = (rem_q != '0);
		character = ser_q[0];
		last      = (rem_q == a85_pkg::A85_DCNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (zstart) begin
				rem_q <= a85_pkg::A85_DCNT_W'(1);
			end else if (finish) begin
				rem_q <= a85_pkg::A85_DCNT_W'(a85_pkg::A85_DIGITS);
			end else if (out_take) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q  <= a85_pkg::A85_PROD_W'(head.entry.value)
				* a85_pkg::A85_PROD_W'(a85_pkg::A85_RECIP);
			vprev_q <= head.entry.value;
		end else if (step) begin
			prod_q  <= a85_pkg::A85_PROD_W'(quot)
				* a85_pkg::A85_PROD_W'(a85_pkg::A85_RECIP);
			vprev_q <= a85_pkg::A85_WORD_W'(quot);
			lo_q[0] <= digit;
			lo_q[1] <= lo_q[0];
			lo_q[2] <= lo_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (zstart) begin
			ser_q[0] <= a85_pkg::A85_ZERO_CHAR;
		end else if (finish) begin
			ser_q[0] <= quot7 + a85_pkg::A85_OFFSET;
			ser_q[1] <= digit + a85_pkg::A85_OFFSET;
			ser_q[2] <= lo_q[0] + a85_pkg::A85_OFFSET;
			ser_q[3] <= lo_q[1] + a85_pkg::A85_OFFSET;
			ser_q[4] <= lo_q[2] + a85_pkg::A85_OFFSET;
		end else if (out_take) begin
			for (int i = 0; i < a85_pkg::A85_DIGITS - 1; i++) begin
				ser_q[i] <= ser_q[i+1];
			end
			ser_q[a85_pkg::A85_DIGITS-1] <= a85_pkg::A85_ZERO_CHAR;
		end
	end

endmodule

@@ rtl/core/ascii85_tuple_encoder.sv @@
// Top level of the ascii85 tuple encoder: front end, queue and digit back end.
// A nonzero word passes the queue, the digit unit and the serializer before its first
// character can be taken; an all-zero 'z' goes from the queue to the serializer.
// Throughput is set by the shared reciprocal multiply unit (one base-85 digit per
// cycle, held while the serializer is busy) and the one-character output port.
// Reset clears the queue, the digit unit and the output count; no clearing pass.
module ascii85_tuple_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [a85_pkg::A85_WORD_W-1:0] word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [a85_pkg::A85_CHAR_W-1:0] character,
	output logic                           last
);

	a85_pkg::a85_entry_t entry;
	a85_pkg::a85_head_t  head;
	logic                push;
	logic                pop;
	logic                full;

	a85_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.word     (word),
		.full     (full),
		.push     (push),
		.entry    (entry)
	);

	a85_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	a85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

@@ sim/tb_ascii85_tuple_encoder.sv @@
// Self-checking testbench for the ascii85 tuple encoder: directed table, then random words.
`timescale 1ns / 100ps

module tb_ascii85_tuple_encoder;

	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned RANDOM_WORDS  = 290;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned DIRECTED_ROWS = 19;

	typedef struct packed {
		logic [a85_pkg::A85_CHAR_W-1:0] character;
		logic                           last;
	} a85_char_t;

	typedef struct packed {
		logic [a85_pkg::A85_WORD_W-1:0] word;
		logic [2:0]                     n_typed;
		logic [39:0]                    text;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [a85_pkg::A85_WORD_W-1:0] word = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [a85_pkg::A85_CHAR_W-1:0] character;
	logic                           last;

	a85_char_t pending_chars[$];
	int        mismatches = 0;
	int        words_sent = 0;
	int        zero_words = 0;
	int        chars_checked = 0;
	int        quiet_cycles = 0;
	int        send_idle_pct = 22;
	int        recv_stall_pct = 58;

	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{32'h0000_0000, 3'd1, "z"},
		'{32'hFFFF_FFFF, 3'd5, "s8W-!"},
		'{32'h0100_0000, 3'd5, "!!!!\""},
		'{32'h5500_0000, 3'd5, "!!!\"!"},
		'{32'hB184_1C03, 3'd5, "\"!!!!"},
		'{32'hB084_1C03, 3'd5, "!uuuu"},
		'{32'h0000_0001, 3'd0, 40'd0},
		'{32'h0000_00FF, 3'd0, 40'd0},
		'{32'h0000_FF00, 3'd0, 40'd0},
		'{32'h00FF_0000, 3'd0, 40'd0},
		'{32'hFF00_0000, 3'd0, 40'd0},
		'{32'h8000_0000, 3'd0, 40'd0},
		'{32'h0000_0080, 3'd0, 40'd0},
		'{32'hAAAA_AAAA, 3'd0, 40'd0},
		'{32'h5555_5555, 3'd0, 40'd0},
		'{32'h0403_0201, 3'd0, 40'd0},
		'{32'h0000_0000, 3'd1, "z"},
		'{32'h0000_0000, 3'd1, "z"},
		'{32'h7FFF_FFFF, 3'd0, 40'd0}
	};

	ascii85_tuple_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.word      (word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] swap_bytes(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Push the characters expected for one word, leading digit first.
	function automatic void encode_word(input logic [a85_pkg::A85_WORD_W-1:0] w);
		logic [31:0]                    rest;
		logic [a85_pkg::A85_CHAR_W-1:0] digits [a85_pkg::A85_DIGITS];
		a85_char_t                      c;
		rest = swap_bytes(w);
		if (rest == 32'd0) begin
			c.character = a85_pkg::A85_ZERO_CHAR;
			c.last = 1'b1;
			pending_chars.push_back(c);
		end else begin
			for (int k = a85_pkg::A85_DIGITS - 1; k >= 0; k--) begin
				digits[k] = a85_pkg::A85_CHAR_W'(rest % 32'(a85_pkg::A85_BASE))
					+ a85_pkg::A85_OFFSET;
				rest = rest / 32'(a85_pkg::A85_BASE);
			end
			for (int k = 0; k < a85_pkg::A85_DIGITS; k++) begin
				c.character = digits[k];
				c.last = (k == a85_pkg::A85_DIGITS - 1);
				pending_chars.push_back(c);
			end
		end
	endfunction

	function automatic void push_typed(input stim_row_t row);
		a85_char_t c;
		for (int k = 0; k < row.n_typed; k++) begin
			c.character = row.text[8*(row.n_typed-1-k) +: a85_pkg::A85_CHAR_W];
			c.last = (k == row.n_typed - 1);
			pending_chars.push_back(c);
		end
	endfunction

	function automatic logic [a85_pkg::A85_WORD_W-1:0] random_word();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(31));
			2: v = 32'($urandom_range(255)) << (8 * $urandom_range(3));
			3: v = swap_bytes(32'($urandom_range(7225)));
			4: v = swap_bytes(32'd52200625 * 32'($urandom_range(1, 82))
				+ 32'($urandom_range(2)) - 32'd1);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic send_word(input logic [a85_pkg::A85_WORD_W-1:0] w,
		input stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			word <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		word <= w;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		if (row.n_typed != 0)
			push_typed(row);
		else
			encode_word(w);
		words_sent++;
		if (w == '0)
			zero_words++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_chars.size() == 0) begin
					report_mismatch($sformatf("character %0d with nothing expected", character));
				end else begin
					if (character !== pending_chars[0].character)
						report_mismatch($sformatf("character %0d, expected %0d",
							character, pending_chars[0].character));
					if (last !== pending_chars[0].last)
						report_mismatch($sformatf("last %b, expected %b on character %0d",
							last, pending_chars[0].last, pending_chars[0].character));
					void'(pending_chars.pop_front());
				end
				chars_checked++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("ascii85_tuple_encoder test failed");
				$finish;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		stim_row_t no_row;
		no_row = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_word(directed_rows[i].word, directed_rows[i]);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 3) begin
				send_idle_pct = 58;
				recv_stall_pct = 22;
			end else if (i == 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			send_word(random_word(), no_row);
		end
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d words (%0d all-zero), checked %0d characters,", words_sent,
			zero_words, chars_checked);
		$display("across mixed, reversed and no-gap sender/receiver idling.");
		if (mismatches == 0)
			$display("ascii85_tuple_encoder test passed");
		else
			$display("ascii85_tuple_encoder test failed");
		$finish;
	end

endmodule
